// ===== sv/gbic_pkg.sv =====
`timescale 1ns / 1ps

package gbic_pkg;

  localparam int BANKS         = 8;
  localparam int PINS_PER_BANK = 32;

  localparam int BANK_IDX_W = (BANKS > 1) ? $clog2(BANKS) : 1;

  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PINS_PER_BANK) - 64'd1);
  localparam logic [5:0]  NO_PENDING = 6'd32;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_IN     = 3'd0,
    REG_OUT    = 3'd1,
    REG_STATUS = 3'd2,
    REG_CLEAR  = 3'd3,
    REG_ENABLE = 3'd4,
    REG_EDGE   = 3'd5,
    REG_POL    = 3'd6,
    REG_OE     = 3'd7
  } reg_sel_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  bank_id;
    logic [2:0]  reg_select;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic [5:0]  first_pending;
    logic [31:0] out_value;
    logic [31:0] out_enable;
  } result_t;

endpackage

// ===== sv/gbic_bank_regs.sv =====
`timescale 1ns / 1ps

module gbic_bank_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  gbic_pkg::item_t item,
  output gbic_pkg::result_t res
);
  import gbic_pkg::*;

  logic [31:0] in_lv_r  [BANKS];
  logic [31:0] out_val_r[BANKS];
  logic [31:0] out_en_r [BANKS];
  logic [31:0] irq_en_r [BANKS];
  logic [31:0] edge_r   [BANKS];
  logic [31:0] pol_r    [BANKS];
  logic [31:0] status_r [BANKS];
  logic [BANKS-1:0] pend_r;

  logic [BANKS-1:0] pend_nxt;
  logic [31:0] in_lv_nxt, out_val_nxt, out_en_nxt, irq_en_nxt;
  logic [31:0] edge_nxt, pol_nxt, status_nxt;
  logic [31:0] wd, lv, rise, fall, edge_hit, level_hit, hit, active;
  logic [31:0] rdata;
  logic [5:0]  first;
  logic [BANK_IDX_W-1:0] idx;
  logic        bank_ok;

  assign idx     = BANK_IDX_W'(item.bank_id);
  assign bank_ok = 32'(item.bank_id) < BANKS;
  assign wd      = item.write_data & PIN_MASK;
  assign lv      = item.pin_levels & PIN_MASK;

  always_comb begin
    in_lv_nxt   = in_lv_r[idx];
    out_val_nxt = out_val_r[idx];
    out_en_nxt  = out_en_r[idx];
    irq_en_nxt  = irq_en_r[idx];
    edge_nxt    = edge_r[idx];
    pol_nxt     = pol_r[idx];
    status_nxt  = status_r[idx];
    rdata       = '0;

    rise      = ~in_lv_r[idx] & lv;
    fall      = in_lv_r[idx] & ~lv;
    edge_hit  = (rise & pol_r[idx]) | (fall & ~pol_r[idx]);
    level_hit = ~(lv ^ pol_r[idx]);
    hit       = ((edge_hit & edge_r[idx]) | (level_hit & ~edge_r[idx])) & PIN_MASK;

    if (bank_ok) begin
      case (item.func)
        FUNC_READ: begin
          case (item.reg_select)
            REG_IN:     rdata = in_lv_r[idx];
            REG_OUT:    rdata = out_val_r[idx];
            REG_STATUS: rdata = status_r[idx];
            REG_ENABLE: rdata = irq_en_r[idx];
            REG_EDGE:   rdata = edge_r[idx];
            REG_POL:    rdata = pol_r[idx];
            REG_OE:     rdata = out_en_r[idx];
            default:    rdata = '0;
          endcase
        end
        FUNC_WRITE: begin
          case (item.reg_select)
            REG_OUT:    out_val_nxt = wd;
            REG_CLEAR:  status_nxt  = status_r[idx] & ~wd;
            REG_ENABLE: irq_en_nxt  = wd;
            REG_EDGE:   edge_nxt    = wd;
            REG_POL:    pol_nxt     = wd;
            REG_OE:     out_en_nxt  = wd;
            default:    ;
          endcase
        end
        FUNC_SAMPLE: begin
          status_nxt = (status_r[idx] | hit) & PIN_MASK;
          in_lv_nxt  = lv;
        end
        default: ;
      endcase
    end
  end

  assign active = status_nxt & irq_en_nxt;

  // lowest set bit wins: scan from the top so the last hit is the lowest
  always_comb begin
    first = NO_PENDING;
    for (int i = 31; i >= 0; i--) begin
      if (active[i]) begin
        first = 6'(i);
      end
    end
  end

  // only the addressed bank can change its pending flag
  always_comb begin
    pend_nxt = pend_r;
    if (bank_ok) begin
      pend_nxt[idx] = |active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BANKS; b++) begin
        in_lv_r[b]   <= '0;
        out_val_r[b] <= '0;
        out_en_r[b]  <= '0;
        irq_en_r[b]  <= '0;
        edge_r[b]    <= '0;
        pol_r[b]     <= '0;
        status_r[b]  <= '0;
      end
      pend_r <= '0;
    end else if (upd) begin
      if (bank_ok) begin
        in_lv_r[idx]   <= in_lv_nxt;
        out_val_r[idx] <= out_val_nxt;
        out_en_r[idx]  <= out_en_nxt;
        irq_en_r[idx]  <= irq_en_nxt;
        edge_r[idx]    <= edge_nxt;
        pol_r[idx]     <= pol_nxt;
        status_r[idx]  <= status_nxt;
      end
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    res.read_data     = rdata;
    res.irq_request   = |pend_nxt;
    res.first_pending = bank_ok ? first : NO_PENDING;
    res.out_value     = bank_ok ? out_val_nxt : '0;
    res.out_enable    = bank_ok ? out_en_nxt : '0;
  end

endmodule

// ===== sv/gpio_bank_interrupt_controller.sv =====
// GPIO bank controller with latched edge/level interrupts.
// Input channel (in_valid/in_stall): one transfer is a bus read, a bus write
// or a pin sample for one bank. Result channel (out_valid/out_stall): one
// transfer per input item, carrying read data, the interrupt request, the
// lowest enabled pending pin of the addressed bank and that bank's output
// and output enable words, all as they stand after the item's update.
// The item is held in an input register; the bank update and priority encode
// run on it once the output register can take the result, and the result lands
// in the output register. Throughput is one item per cycle while out_stall is
// low; the register file update plus the 32-bit priority encode set the cycle.
// A stall on the result side holds the output register; the input register
// still empties into it as soon as the waiting result is taken, so in_stall
// rises only when both registers are full.
// Synchronous reset clears every bank register, the pending flags and the
// valid flags of both pipeline registers.
`timescale 1ns / 1ps

module gpio_bank_interrupt_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_bank_id,
  input  logic [2:0]  in_reg_select,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_request,
  output logic [5:0]  out_first_pending,
  output logic [31:0] out_out_value,
  output logic [31:0] out_out_enable
);
  import gbic_pkg::*;

  item_t   item_r, item_nxt;
  logic    item_vld_r, item_vld_nxt;
  result_t res_r, res_nxt;
  logic    out_vld_r, out_vld_nxt;
  result_t res_calc;
  logic    out_ready, adv, in_xfer;

  assign out_ready = !out_vld_r || !out_stall;
  assign adv       = item_vld_r && out_ready;
  assign in_stall  = item_vld_r && !out_ready;
  assign in_xfer   = in_valid && !in_stall;

  gbic_bank_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (adv),
    .item  (item_r),
    .res   (res_calc)
  );

  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (in_xfer) begin
      item_nxt.func       = in_func;
      item_nxt.bank_id    = in_bank_id;
      item_nxt.reg_select = in_reg_select;
      item_nxt.write_data = in_write_data;
      item_nxt.pin_levels = in_pin_levels;
      item_vld_nxt        = 1'b1;
    end else if (adv) begin
      item_vld_nxt = 1'b0;
    end

    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      res_nxt     = res_calc;
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = res_r.read_data;
  assign out_irq_request   = res_r.irq_request;
  assign out_first_pending = res_r.first_pending;
  assign out_out_value     = res_r.out_value;
  assign out_out_enable    = res_r.out_enable;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result lost on its way to the output register");

  a_pending_implies_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_pending != NO_PENDING |-> out_irq_request)
    else $error("pending pin reported without interrupt request");

  a_first_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_pending <= NO_PENDING)
    else $error("first pending pin out of range");

endmodule
